@@ rtl/heq_pkg.sv @@
// Shared types and constants of the histogram equalizer.
// Holds opcodes, register indexes, fixed field widths and the command struct
// that the controller sends to the datapath. No dependencies.
package heq_pkg;

    // Fixed field widths.
    localparam int BIN_W  = 8;
    localparam int PIX_W  = 8;
    localparam int OP_W   = 2;
    localparam int DIM_W  = 13;
    localparam int TOT_W  = 2 * DIM_W;
    localparam int Q_W    = 8;
    localparam int STEP_W = $clog2(Q_W);

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Opcodes carried in tuser.
    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
    localparam logic [BIN_W-1:0] BIN_MAX = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             cnt_go;
        logic             map_go;
        logic             build_go;
        logic             hist_rd;
        logic             acc;
        logic             mul;
        logic             div_init;
        logic             div_step;
        logic             map_wr;
        logic             hist_clr;
        logic [BIN_W-1:0] bin;
    } heq_cmd_t;

endpackage

@@ rtl/heq_ctrl.sv @@
// Controller of the histogram equalizer: item acceptance and the table build
// sequencer (one bin at a time, eight divide steps per bin).
// Depends on heq_pkg.
module heq_ctrl
    import heq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] opcode,
    input  logic            out_busy,
    output logic            in_ready,
    output heq_cmd_t        cmd
);

    localparam logic [2:0] S_RUN  = 3'd0;
    localparam logic [2:0] S_BRD  = 3'd1;
    localparam logic [2:0] S_BACC = 3'd2;
    localparam logic [2:0] S_BMUL = 3'd3;
    localparam logic [2:0] S_BSAT = 3'd4;
    localparam logic [2:0] S_BDIV = 3'd5;
    localparam logic [2:0] S_BWR  = 3'd6;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);

    logic [2:0]        state_reg, state_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              accept;

    // Outside a build, a map item waits only while the output register holds an untaken item.
    assign in_ready = (state_reg == S_RUN) && !((opcode == OP_MAP) && out_busy);
    assign accept   = in_valid && in_ready;

    // Next state and command decode.
    always_comb
    begin
        cmd        = '0;
        cmd.bin    = bin_reg;
        state_next = state_reg;
        bin_next   = bin_reg;
        step_next  = step_reg;
        case (state_reg)
            S_RUN:
            begin
                cmd.cnt_go = accept && (opcode == OP_COUNT);
                cmd.map_go = accept && (opcode == OP_MAP);
                if (accept && (opcode == OP_BUILD))
                begin
                    cmd.build_go = 1'b1;
                    bin_next     = '0;
                    state_next   = S_BRD;
                end
            end
            S_BRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_BACC;
            end
            S_BACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_BSAT;
            end
            S_BSAT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_BDIV;
            end
            S_BDIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_BWR;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_BWR:
            begin
                cmd.map_wr = 1'b1;
                if (bin_reg == BIN_MAX)
                begin
                    cmd.hist_clr = 1'b1;
                    state_next   = S_RUN;
                end
                else
                begin
                    bin_next   = bin_reg + BIN_W'(1);
                    state_next = S_BRD;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            bin_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bin_reg   <= bin_next;
            step_reg  <= step_next;
        end
    end

    // A build item always starts the sweep at the first bin.
    a_build_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_BUILD)) |=> ((state_reg == S_BRD) && (bin_reg == '0)))
        else $error("build did not start at bin zero");

    // The last divide step hands over to the table write.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BDIV) && (step_reg == STEP_LAST)) |=> (state_reg == S_BWR))
        else $error("divide sequence did not end in a table write");

    // Writing the last bin returns the block to accepting items.
    a_build_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BWR) && (bin_reg == BIN_MAX)) |=> (state_reg == S_RUN))
        else $error("build did not end after the last bin");

endmodule

@@ rtl/heq_dpath.sv @@
// Datapath of the histogram equalizer: histogram memory with its counting
// pipeline, the table build arithmetic (scale, saturate, radix-2 divide),
// the mapping table memory and the output register. Depends on heq_pkg.
module heq_dpath
    import heq_pkg::*;
#(
    parameter int COUNT_BITS = 25
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  heq_cmd_t         cmd,
    input  logic [PIX_W-1:0] pixel,
    input  logic [DIM_W-1:0] width,
    input  logic [DIM_W-1:0] height,
    input  logic             out_ready,
    output logic             out_busy,
    output logic             out_valid,
    output logic [PIX_W-1:0] mapped_pixel
);

    localparam int CUM_W = COUNT_BITS + BIN_W;
    localparam int NUM_W = CUM_W + Q_W;
    localparam int LIM_W = TOT_W + Q_W;
    localparam int REM_W = (NUM_W > LIM_W) ? NUM_W : LIM_W;
    localparam int BINS  = 1 << BIN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Histogram storage and counting pipeline.
    logic [COUNT_BITS-1:0] hist_mem [BINS];
    logic [BINS-1:0]       hist_vld_reg;
    logic [BIN_W-1:0]      hist_raddr;
    logic                  hist_rd_en;
    logic [COUNT_BITS-1:0] hist_rd_reg;
    logic                  hist_rd_vld_reg;
    logic [COUNT_BITS-1:0] hist_cnt;
    logic                  s2_vld_reg;
    logic [BIN_W-1:0]      s2_addr_reg;
    logic                  fwd_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] s2_cur;
    logic [COUNT_BITS-1:0] s2_new;

    // Table build arithmetic.
    logic [TOT_W-1:0]      total_reg;
    logic [CUM_W-1:0]      cum_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [REM_W-1:0]      dsh_reg;
    logic [Q_W-1:0]        quo_reg;
    logic                  sat_reg;
    logic [REM_W-1:0]      sat_limit;
    logic [PIX_W-1:0]      map_wdata;

    // Mapping table and output.
    logic [PIX_W-1:0]      map_mem [BINS];
    logic [BINS-1:0]       map_vld_reg;
    logic [PIX_W-1:0]      map_rd_reg;
    logic                  map_rd_vld_reg;
    logic                  out_vld_reg;

    // The build sweep and counting items share the one histogram read port.
    assign hist_raddr = cmd.hist_rd ? cmd.bin : pixel;
    assign hist_rd_en = cmd.hist_rd || cmd.cnt_go;
    assign hist_cnt   = hist_rd_vld_reg ? hist_rd_reg : '0;

    // A count to the bin written in the cycle of its read takes the new value.
    assign s2_cur = fwd_reg ? fwd_data_reg : hist_cnt;
    assign s2_new = (s2_cur == COUNT_MAX) ? s2_cur : s2_cur + COUNT_BITS'(1);

    always_ff @(posedge clk)
    begin
        if (hist_rd_en)
        begin
            hist_rd_reg     <= hist_mem[hist_raddr];
            hist_rd_vld_reg <= hist_vld_reg[hist_raddr];
        end
        if (s2_vld_reg)
        begin
            hist_mem[s2_addr_reg] <= s2_new;
        end
        if (cmd.cnt_go)
        begin
            s2_addr_reg  <= pixel;
            fwd_reg      <= s2_vld_reg && (s2_addr_reg == pixel);
            fwd_data_reg <= s2_new;
        end
    end

    // Histogram valid bits: a bin not yet counted since the last clear reads zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            s2_vld_reg   <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= cmd.cnt_go;
            if (cmd.hist_clr)
            begin
                hist_vld_reg <= '0;
            end
            else if (s2_vld_reg)
            begin
                hist_vld_reg[s2_addr_reg] <= 1'b1;
            end
        end
    end

    // Entry is 255 * cum / total; it saturates once 255 * cum >= 256 * total,
    // otherwise the quotient fits eight bits and is found one bit per cycle.
    assign sat_limit = REM_W'({total_reg, {Q_W{1'b0}}});
    assign map_wdata = sat_reg ? PIX_MAX : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.build_go)
        begin
            cum_reg   <= '0;
            total_reg <= TOT_W'(width) * TOT_W'(height);
        end
        else if (cmd.acc)
        begin
            cum_reg <= cum_reg + CUM_W'(hist_cnt);
        end
        if (cmd.mul)
        begin
            num_reg <= {cum_reg, {Q_W{1'b0}}} - NUM_W'(cum_reg);
        end
        if (cmd.div_init)
        begin
            sat_reg <= REM_W'(num_reg) >= sat_limit;
            rem_reg <= REM_W'(num_reg);
            dsh_reg <= REM_W'({total_reg, {(Q_W-1){1'b0}}});
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Mapping table memory and its registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.map_wr)
        begin
            map_mem[cmd.bin] <= map_wdata;
        end
        if (cmd.map_go)
        begin
            map_rd_reg     <= map_mem[pixel];
            map_rd_vld_reg <= map_vld_reg[pixel];
        end
    end

    // Table valid bits and the output register's valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.map_wr)
            begin
                map_vld_reg[cmd.bin] <= 1'b1;
            end
            if (cmd.map_go)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_busy     = out_vld_reg && !out_ready;
    assign mapped_pixel = map_rd_vld_reg ? map_rd_reg : '0;

    // A pending count write never meets a build read of the histogram.
    a_no_count_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> !cmd.hist_rd)
        else $error("count write overlaps table build");

    // Clearing the histogram empties every bin.
    a_hist_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_clr |=> (hist_vld_reg == '0))
        else $error("histogram not cleared after build");

    // A result appears only from a map item.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(cmd.map_go))
        else $error("result without a map item");

endmodule

@@ rtl/histogram_equalizer_top.sv @@
// Histogram equalizer for 8-bit grey images. Items arrive on the s_ stream with
// the opcode in s_tuser (0 count pixel, 1 build table, 2 map pixel) and the
// pixel in s_tdata; only map items produce a result on the m_ stream. Outside
// a build, count and map items are taken one per cycle; a map item waits only
// while the output register still holds an untaken result. A build item occupies
// the block from its acceptance until the last bin is written: the sequencer
// visits the 256 bins one at a time, reading each through the single histogram
// read port and dividing in the shared radix-2 divider that yields one quotient
// bit per cycle. No clearing pass is needed after reset. Registers: image_width
// at 0x0, image_height at 0x4; a write keeps bits [12:0], 0 stores 1 and values
// above MAX_DIM store MAX_DIM. Depends on heq_pkg, heq_ctrl and heq_dpath.
module histogram_equalizer_top
    import heq_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int COUNT_BITS = 25
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [PIX_W-1:0]  s_tdata,   // [7:0] pixel
    input  logic [OP_W-1:0]   s_tuser,   // [1:0] opcode
    // Output stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PIX_W-1:0]  m_tdata,   // [7:0] mapped_pixel
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_wr;
    logic             cfg_sel;
    logic [DIM_W-1:0] cfg_dim;
    heq_cmd_t         cmd;
    logic             out_busy;

    // Limit a written dimension to 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (32'(v) > 32'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

    // Register access decode.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[2];
    assign cfg_dim = clamp_dim(pwdata[DIM_W-1:0]);
    assign prdata  = (cfg_sel == REG_HEIGHT) ? {{(APB_DW-DIM_W){1'b0}}, height_reg}
                                             : {{(APB_DW-DIM_W){1'b0}}, width_reg};

    // Image dimension registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_wr)
        begin
            if (cfg_sel == REG_WIDTH)
            begin
                width_reg <= cfg_dim;
            end
            else
            begin
                height_reg <= cfg_dim;
            end
        end
    end

    heq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .opcode   (s_tuser),
        .out_busy (out_busy),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    heq_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .pixel        (s_tdata),
        .width        (width_reg),
        .height       (height_reg),
        .out_ready    (m_tready),
        .out_busy     (out_busy),
        .out_valid    (m_tvalid),
        .mapped_pixel (m_tdata)
    );

endmodule
